[design/rled_pkg.sv]
// Package for the escape-byte run-length decoder.
// Types, codes and default sizes shared by the decoder modules; depends on nothing.
`default_nettype none

package rled_pkg;

	// Default sizes, handed down from the top level
	localparam int BYTES_PER_RESULT_DEF = 4;
	localparam int LENGTH_BITS_DEF      = 24;
	localparam int QUEUE_DEPTH_DEF      = 2;

	// Fixed by the result format
	localparam int MAX_RESULTS = 64;
	localparam int DATA_LANES  = 4;
	localparam int CAP_BITS    = 24;

	// Header byte that selects escape mode
	localparam logic [7:0] MODE_Y = 8'h59;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_ESCKEY = 3'd1,
		PH_DATA   = 3'd2,
		PH_VALUE  = 3'd3,
		PH_COUNT  = 3'd4,
		PH_RAW    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_TRUNC    = 2'd2
	} status_t;

	// One classified input item: count copies of value (a literal has count 1)
	typedef struct packed {
		logic [7:0] value;
		logic [7:0] count;
		logic       last;
		logic       trunc;
	} cmd_t;

endpackage

`default_nettype wire

[design/rled_if.sv]
// Handshake channels of the decoder: compressed bytes in, packed results out.
// Valid/ready with payload; no dependencies.
`default_nettype none

interface rled_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface rled_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_data;
	logic [2:0]  out_count;
	logic        item_done;
	logic        stream_end;
	logic [23:0] total_length;
	logic [1:0]  status;

	modport source (output valid, output out_data, output out_count, output item_done,
		output stream_end, output total_length, output status, input ready);
	modport sink (input valid, input out_data, input out_count, input item_done,
		input stream_end, input total_length, input status, output ready);
endinterface

`default_nettype wire

[design/rle_escape_decoder_unit.sv]
// Top level of the escape-byte run-length decoder: capacity register, front end,
// command queue and back end. Depends on rled_pkg, rled_if, rled_front, rled_queue, rled_back.
//
// Decodes one compressed byte per accepted item. The first byte of a stream picks
// the mode ('Y' selects escape mode, with the escape byte next); an escape, value,
// count triplet expands to count copies of value, other bytes pass through, and
// the final result of a stream carries its length and status. Literal bytes flow
// at one item per cycle while the queue has room and the receiver is ready. Runs
// hold the back end, cut into BYTES_PER_RESULT-byte results, one per cycle while
// the receiver is ready; the queue keeps accepting input until full. Header, escape
// and value bytes give no result unless they close the stream. The user must
// write the capacity register only while idle; the block does not enforce it. It
// takes effect on the next stream byte; there is no clearing pass after reset.
`default_nettype none

module rle_escape_decoder_unit
	import rled_pkg::*;
#(
	parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF,
	parameter int LENGTH_BITS      = LENGTH_BITS_DEF,
	parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                capacity_we,
	input  wire logic [CAP_BITS-1:0] capacity_wdata,
	rled_byte_if.sink                stream,
	rled_result_if.source            result
);

	logic [LENGTH_BITS-1:0]          cap_q;
	logic [LENGTH_BITS+CAP_BITS-1:0] cap_wide;
	logic [LENGTH_BITS+CAP_BITS-1:0] cap_rst_wide;
	logic                            push;
	cmd_t                            push_cmd;
	logic                            q_full;
	logic                            pop;
	logic                            q_valid;
	cmd_t                            q_cmd;

	// Fit the written capacity to the length width
	assign cap_wide     = {{LENGTH_BITS{1'b0}}, capacity_wdata};
	assign cap_rst_wide = {{LENGTH_BITS{1'b0}}, {CAP_BITS{1'b1}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cap_rst_wide[LENGTH_BITS-1:0];
		end else if (capacity_we) begin
			cap_q <= cap_wide[LENGTH_BITS-1:0];
		end
	end

	rled_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.q_full (q_full),
		.push   (push),
		.cmd    (push_cmd)
	);

	rled_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (q_valid),
		.head_cmd   (q_cmd)
	);

	rled_back #(
		.BYTES_PER_RESULT (BYTES_PER_RESULT),
		.LENGTH_BITS      (LENGTH_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (cap_q),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire

[design/rled_front.sv]
// Front end: accepts compressed bytes, tracks the header/escape phase and
// turns each item into a run command. Depends on rled_pkg and rled_byte_if.
`default_nettype none

module rled_front
	import rled_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	rled_byte_if.sink   stream,
	input  wire logic   q_full,
	output logic        push,
	output cmd_t        cmd
);

	phase_t     phase_q;
	phase_t     phase_d;
	logic [7:0] esc_q;
	logic [7:0] run_q;
	logic       fire;
	logic       keep;

	assign stream.ready = !q_full;
	assign fire         = stream.valid && stream.ready;

	// Next phase from the current byte
	always_comb begin
		case (phase_q)
			PH_ESCKEY: phase_d = PH_DATA;
			PH_DATA:   phase_d = (stream.in_byte == esc_q) ? PH_VALUE : PH_DATA;
			PH_VALUE:  phase_d = PH_COUNT;
			PH_COUNT:  phase_d = PH_DATA;
			PH_RAW:    phase_d = PH_RAW;
			default:   phase_d = (stream.in_byte == MODE_Y) ? PH_ESCKEY : PH_RAW;
		endcase
	end

	// Classify the item into a command
	always_comb begin
		keep      = 1'b0;
		cmd.value = stream.in_byte;
		cmd.count = 8'd1;
		case (phase_q)
			PH_DATA: keep = (stream.in_byte != esc_q);
			PH_COUNT: begin
				keep      = 1'b1;
				cmd.value = run_q;
				cmd.count = stream.in_byte;
			end
			PH_RAW:  keep = 1'b1;
			default: keep = 1'b0;
		endcase
		if (!keep) begin
			cmd.count = 8'd0;
		end
		cmd.last  = stream.in_last;
		cmd.trunc = stream.in_last && ((phase_d == PH_VALUE) || (phase_d == PH_COUNT));
		// Drop items that yield nothing unless they close the stream
		push      = fire && (keep || stream.in_last);
	end

	// Advance phase and capture escape and run bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			esc_q   <= 8'd0;
			run_q   <= 8'd0;
		end else if (fire) begin
			phase_q <= stream.in_last ? PH_HEADER : phase_d;
			if (phase_q == PH_ESCKEY) begin
				esc_q <= stream.in_byte;
			end
			if (phase_q == PH_VALUE) begin
				run_q <= stream.in_byte;
			end
		end
	end

endmodule

`default_nettype wire

[design/rled_queue.sv]
// Short command queue between the front and back ends.
// Holds cmd_t entries in arrival order; depends on rled_pkg.
`default_nettype none

module rled_queue
	import rled_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output cmd_t      head_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign full       = (fill_q == CW'(DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[design/rled_back.sv]
// Back end: applies the capacity limit to each command, counts decoded bytes
// and packs them into registered results. Depends on rled_pkg and rled_result_if.
`default_nettype none

module rled_back
	import rled_pkg::*;
#(
	parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF,
	parameter int LENGTH_BITS      = LENGTH_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [LENGTH_BITS-1:0] capacity,
	input  wire logic                   q_valid,
	input  wire cmd_t                   q_cmd,
	output logic                        pop,
	rled_result_if.source               result
);

	localparam int EMIT_MAX = MAX_RESULTS * BYTES_PER_RESULT;

	// Run in progress
	logic                   active_q;
	logic [7:0]             rem_q;
	logic [7:0]             val_q;
	logic                   last_q;
	logic [LENGTH_BITS-1:0] total_q;
	status_t                status_q;

	// Per-stream counters
	logic [LENGTH_BITS-1:0] decoded_q;
	logic                   ovf_q;

	// Output register
	logic                   out_valid_q;
	logic [31:0]            data_q;
	logic [2:0]             count_q;
	logic                   done_q;
	logic                   end_q;
	logic [23:0]            length_q;
	logic [1:0]             stat_q;

	logic                   below;
	logic [LENGTH_BITS-1:0] room;
	logic                   over;
	logic [7:0]             kept;
	logic [7:0]             nemit;
	logic [LENGTH_BITS-1:0] total_new;
	status_t                status_new;
	logic                   start;
	logic                   emit;
	logic                   last_chunk;
	logic [3:0]             chunk;
	logic [31:0]            lanes;
	logic [LENGTH_BITS+23:0] total_wide;

	// Limit the command against the remaining capacity
	always_comb begin
		below     = (decoded_q < capacity);
		room      = below ? (capacity - decoded_q) : '0;
		over      = (LENGTH_BITS'(q_cmd.count) > room);
		kept      = over ? room[7:0] : q_cmd.count;
		nemit     = (10'(kept) > 10'(EMIT_MAX)) ? 8'(EMIT_MAX) : kept;
		total_new = below ? (decoded_q + LENGTH_BITS'(kept)) : capacity;
		if (q_cmd.trunc) begin
			status_new = ST_TRUNC;
		end else if (ovf_q || over) begin
			status_new = ST_OVERFLOW;
		end else begin
			status_new = ST_OK;
		end
		start = (nemit != 8'd0) || q_cmd.last;
	end

	// Cut the next chunk of the run
	always_comb begin
		emit       = active_q && (!out_valid_q || result.ready);
		last_chunk = (rem_q <= 8'(BYTES_PER_RESULT));
		chunk      = last_chunk ? rem_q[3:0] : 4'(BYTES_PER_RESULT);
		for (int i = 0; i < DATA_LANES; i++) begin
			lanes[8*i +: 8] = (4'(i) < chunk) ? val_q : 8'd0;
		end
		pop        = q_valid && (!active_q || (emit && last_chunk));
		total_wide = {24'd0, total_q};
	end

	// Take a command and update the stream counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			decoded_q <= '0;
			ovf_q     <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= start;
				if (q_cmd.last) begin
					decoded_q <= '0;
					ovf_q     <= 1'b0;
				end else begin
					decoded_q <= below ? total_new : decoded_q;
					ovf_q     <= ovf_q || over;
				end
			end else if (emit && last_chunk) begin
				active_q <= 1'b0;
			end
		end
	end

	// Hold run payload; step the remaining count
	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q    <= nemit;
			val_q    <= q_cmd.value;
			last_q   <= q_cmd.last;
			total_q  <= total_new;
			status_q <= status_new;
		end else if (emit) begin
			rem_q <= rem_q - 8'(chunk);
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			data_q   <= lanes;
			count_q  <= chunk[2:0];
			done_q   <= last_chunk;
			end_q    <= last_chunk && last_q;
			length_q <= (last_chunk && last_q) ? total_wide[23:0] : 24'd0;
			stat_q   <= (last_chunk && last_q) ? status_q : ST_OK;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.out_data     = data_q;
	assign result.out_count    = count_q;
	assign result.item_done    = done_q;
	assign result.stream_end   = end_q;
	assign result.total_length = length_q;
	assign result.status       = stat_q;

endmodule

`default_nettype wire

[test/tb_rle_escape_decoder_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rle_escape_decoder_unit: directed and random streams
// against a built-in decoder model. Depends on rled_pkg, rled_if and the design.

module tb_rle_escape_decoder_unit
	import rled_pkg::*;
();

	localparam int LANES       = BYTES_PER_RESULT_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE      = 8;

	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  count;
		logic        done;
		logic        ends;
		logic [23:0] total;
		status_t     status;
	} decoded_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic capacity_we;
	logic [CAP_BITS-1:0] capacity_wdata;

	rled_byte_if   stream_ch();
	rled_result_if result_ch();

	rle_escape_decoder_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata),
		.stream         (stream_ch),
		.result         (result_ch)
	);

	// Decoder model state
	phase_t        model_phase;
	logic [7:0]    model_escape;
	logic [7:0]    model_run;
	logic [24:0]   model_count;
	logic          model_overflow;
	logic [23:0]   model_capacity;
	logic [7:0]    fresh_bytes[$];
	decoded_word_t expected_words[$];

	int mismatches;
	int idle_cycles;
	int send_idle_pct;
	int recv_stall_pct;

	// Clock: 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Keep one decoded byte, or drop it once the capacity is used up
	task automatic keep_byte(input logic [7:0] b);
		if (model_count < {1'b0, model_capacity}) begin
			fresh_bytes.push_back(b);
			model_count++;
		end else begin
			model_overflow = 1'b1;
		end
	endtask

	// Advance the model by one accepted byte and queue the words it decodes to
	task automatic predict_byte(input logic [7:0] b, input logic last);
		int n_words;
		int pos;
		int lanes;
		logic [23:0] total;
		status_t st;
		decoded_word_t w;
		fresh_bytes = {};
		case (model_phase)
			PH_ESCKEY: begin
				model_escape = b;
				model_phase = PH_DATA;
			end
			PH_DATA: begin
				if (b == model_escape)
					model_phase = PH_VALUE;
				else
					keep_byte(b);
			end
			PH_VALUE: begin
				model_run = b;
				model_phase = PH_COUNT;
			end
			PH_COUNT: begin
				for (int i = 0; i < b; i++)
					keep_byte(model_run);
				model_phase = PH_DATA;
			end
			PH_RAW: keep_byte(b);
			default: model_phase = (b == MODE_Y) ? PH_ESCKEY : PH_RAW;
		endcase

		// Truncated triplet wins over overflow
		if (model_phase == PH_VALUE || model_phase == PH_COUNT)
			st = ST_TRUNC;
		else if (model_overflow)
			st = ST_OVERFLOW;
		else
			st = ST_OK;
		total = (model_count < {1'b0, model_capacity}) ? model_count[23:0] : model_capacity;

		n_words = (fresh_bytes.size() + LANES - 1) / LANES;
		if (last && n_words == 0)
			n_words = 1;
		if (n_words > MAX_RESULTS)
			n_words = MAX_RESULTS;

		// Pack the bytes, first byte in the lowest lane
		pos = 0;
		for (int r = 0; r < n_words; r++) begin
			w = '0;
			lanes = 0;
			while (lanes < LANES && pos < fresh_bytes.size()) begin
				w.data[8*lanes +: 8] = fresh_bytes[pos];
				lanes++;
				pos++;
			end
			w.count = 3'(lanes);
			w.done = (r == n_words - 1);
			w.ends = last && w.done;
			if (w.ends) begin
				w.total = total;
				w.status = st;
			end
			expected_words.push_back(w);
		end

		if (last) begin
			model_phase = PH_HEADER;
			model_count = '0;
			model_overflow = 1'b0;
		end
	endtask

	// Send one item, with random gaps ahead of it, and predict it on acceptance
	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			stream_ch.valid <= 1'b0;
			@(negedge clk);
		end
		stream_ch.valid <= 1'b1;
		stream_ch.in_byte <= b;
		stream_ch.in_last <= last;
		do
			@(posedge clk);
		while (!stream_ch.ready);
		predict_byte(b, last);
	endtask

	task automatic send_stream(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// Hold off the sender and wait until every expected word is out
	task automatic wait_drained();
		@(negedge clk);
		stream_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [23:0] value);
		wait_drained();
		@(negedge clk);
		capacity_we <= 1'b1;
		capacity_wdata <= value;
		model_capacity = value;
		@(negedge clk);
		capacity_we <= 1'b0;
	endtask

	// Build one random stream: mostly well-formed escape streams, some raw and noise
	task automatic send_random_stream(inout int sent);
		logic [7:0] bytes[$];
		logic [7:0] esc;
		logic [7:0] v;
		int kind;
		if ($urandom_range(99) < 80) begin
			esc = 8'($urandom);
			bytes.push_back(MODE_Y);
			bytes.push_back(esc);
			repeat ($urandom_range(0, 10)) begin
				kind = $urandom_range(99);
				if (kind < 55) begin
					v = 8'($urandom);
					while (v == esc)
						v = 8'($urandom);
					bytes.push_back(v);
				end else if (kind < 95) begin
					bytes.push_back(esc);
					bytes.push_back(8'($urandom));
					if ($urandom_range(99) < 90)
						bytes.push_back(8'($urandom_range(0, 12)));
					else
						bytes.push_back(8'($urandom_range(0, 255)));
				end else begin
					bytes.push_back(8'($urandom));
				end
			end
			// Cut some streams inside a triplet
			if ($urandom_range(99) < 10) begin
				bytes.push_back(esc);
				if ($urandom_range(1))
					bytes.push_back(8'($urandom));
			end
		end else begin
			bytes.push_back(8'($urandom));
			repeat ($urandom_range(0, 12))
				bytes.push_back(8'($urandom));
		end
		send_stream(bytes);
		sent += bytes.size();
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Receiver: stall at the phase's rate
	always @(negedge clk)
		result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	// Compare each accepted word with the oldest expectation
	always @(posedge clk) begin : check_words
		decoded_word_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, actual data %0h count %0d", $time,
					result_ch.out_data, result_ch.out_count);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				check_field("out_data", want.data, result_ch.out_data);
				check_field("out_count", 32'(want.count), 32'(result_ch.out_count));
				check_field("item_done", 32'(want.done), 32'(result_ch.item_done));
				check_field("stream_end", 32'(want.ends), 32'(result_ch.stream_end));
				check_field("total_length", 32'(want.total), 32'(result_ch.total_length));
				check_field("status", 32'(want.status), 32'(result_ch.status));
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Header-only raw stream, a lone 'Y', and 'Y' with its escape byte
	task automatic test_short_streams();
		send_stream('{8'h00});
		send_stream('{MODE_Y});
		send_stream('{MODE_Y, 8'h3C});
	endtask

	task automatic test_raw_mode();
		send_stream('{8'hFF, 8'h00, MODE_Y, 8'hFF});
	endtask

	// High escape byte, zero count, escape byte as run value, longest run
	task automatic test_escape_runs();
		send_stream('{MODE_Y, 8'hF0, 8'hF0, 8'h41, 8'h00, 8'hF0, 8'hF0, 8'hFF, 8'h80});
	endtask

	// Streams that end after the escape, and after escape and value
	task automatic test_truncated();
		send_stream('{MODE_Y, 8'h10, 8'h10});
		send_stream('{MODE_Y, 8'h10, 8'h10, 8'h44});
	endtask

	task automatic test_capacity();
		// Zero capacity drops everything
		set_capacity(24'h000000);
		send_stream('{8'h00, 8'h11});
		// Truncation wins over overflow
		set_capacity(24'h000001);
		send_stream('{MODE_Y, 8'hE0, 8'h22, 8'h33, 8'hE0});
		// Lower the capacity between streams, then restore it
		set_capacity(24'hFFFFFF);
		send_stream('{MODE_Y, 8'hE0, 8'hE0, 8'h55, 8'h06});
		set_capacity(24'h000003);
		send_byte(8'h22, 1'b1);
		set_capacity(24'hFFFFFF);
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct,
		input logic [23:0] capacity, input int n_items);
		int sent;
		set_capacity(capacity);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items)
			send_random_stream(sent);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		capacity_we = 1'b0;
		capacity_wdata = '0;
		stream_ch.valid = 1'b0;
		stream_ch.in_byte = '0;
		stream_ch.in_last = 1'b0;
		result_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		idle_cycles = 0;
		model_phase = PH_HEADER;
		model_escape = '0;
		model_run = '0;
		model_count = '0;
		model_overflow = 1'b0;
		model_capacity = 24'hFFFFFF;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_short_streams();
		test_raw_mode();
		test_escape_runs();
		test_truncated();
		test_capacity();

		test_random_phase(0, 0, 24'hFFFFFF, 100);
		test_random_phase(80, 0, 24'($urandom_range(20, 60)), 100);
		test_random_phase(0, 80, 24'hFFFFFF, 100);
		test_random_phase(18, 18, 24'($urandom_range(1, 15)), 100);

		if (mismatches == 0 && expected_words.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
